// ===== rtl/pgf_pkg.sv =====
package pgf_pkg;

	localparam int INTEG_W    = 48;
	localparam int QUARTER_W  = 8;
	localparam int BEAM_W     = 8;
	localparam int SEQ_W      = INTEG_W + QUARTER_W;
	localparam int PPC_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int MAX_FILL    = 63;
	localparam int FILL_W      = $clog2(MAX_FILL + 1);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [QUARTER_W-1:0] QPS_RESET = 8'd4;
	localparam logic [PPC_W-1:0]     PPC_RESET = 16'd128;
	localparam logic [1:0]           STARTUP_RESET = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_QPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PPC = 1'b1;

	typedef struct packed {
		logic [INTEG_W-1:0]   integration_count;
		logic [QUARTER_W-1:0] spectral_quarter;
		logic [BEAM_W-1:0]    beam_number;
	} in_req_t;

	typedef struct packed {
		logic                 is_fill;
		logic [INTEG_W-1:0]   out_integration;
		logic [QUARTER_W-1:0] out_quarter;
		logic [BEAM_W-1:0]    out_beam;
		logic                 gap_clipped;
		logic                 out_of_order;
		logic                 end_of_chunk;
		logic                 last_of_run;
	} out_req_t;

	typedef struct packed {
		logic                 drop;
		logic [FILL_W-1:0]    fills;
		logic                 clip;
		logic                 ooo;
		logic [INTEG_W-1:0]   integ;
		logic [QUARTER_W-1:0] quarter;
		logic [BEAM_W-1:0]    beam;
	} cmd_t;

endpackage

// ===== rtl/packet_gap_filler_top.sv =====
// Packet gap filler. Decoded packet headers arrive as requests on the in_* channel
// (valid/ready) and leave as headers on the out_* channel (valid/ready). Each accepted
// request yields zero results during start-up, or up to 63 fill headers followed by
// the real header, which carries last_of_run. Registers are written through cfg_we,
// cfg_index and cfg_data: index 0 sets quarters_per_spectrum, index 1 sets
// packets_per_chunk. Write them only while the block is idle.
// The front side takes no new request until it has pushed the last one: it holds a header
// through its multiply, subtract and classify steps. A result passes through those steps,
// the queue and the output register. The back side emits one header per cycle while the
// receiver is ready; before the fills of a request, a bit-serial remainder step reduces
// the previous quarter when it lies at or beyond quarters_per_spectrum.
// A two-entry queue separates the sides. The output register holds a header while the
// receiver stalls; that stops the back side, and the front side once the queue fills.
// Reset restarts start-up, clears the sequence history and the chunk position, and
// restores the registers to 4 quarters per spectrum and 128 packets per chunk.
module packet_gap_filler_top #(
	parameter int QDEPTH = pgf_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pgf_pkg::in_req_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pgf_pkg::out_req_t                 out_data,
	input  logic                              cfg_we,
	input  logic [pgf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pgf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [pgf_pkg::QUARTER_W-1:0] qps_q;
	logic [pgf_pkg::PPC_W-1:0]     ppc_q;
	logic [pgf_pkg::QUARTER_W-1:0] qps_eff;

	logic          push;
	pgf_pkg::cmd_t push_cmd;
	logic          q_full;
	logic          pop;
	pgf_pkg::cmd_t head;
	logic          q_empty;

	// A zero quarter count behaves as one.
	assign qps_eff = (qps_q == '0) ? pgf_pkg::QUARTER_W'(1) : qps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qps_q <= pgf_pkg::QPS_RESET;
			ppc_q <= pgf_pkg::PPC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pgf_pkg::CFG_QPS: qps_q <= cfg_data[pgf_pkg::QUARTER_W-1:0];
				pgf_pkg::CFG_PPC: ppc_q <= cfg_data[pgf_pkg::PPC_W-1:0];
				default: ;
			endcase
		end
	end

	pgf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.qps      (qps_eff),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	pgf_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	pgf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qps       (qps_eff),
		.ppc       (ppc_q),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/pgf_front.sv =====
module pgf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pgf_pkg::QUARTER_W-1:0]  qps,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pgf_pkg::in_req_t               in_data,
	output logic                           push,
	output pgf_pkg::cmd_t                  push_cmd,
	input  logic                           q_full
);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUB, F_PUSH} state_t;

	state_t                      state_q;
	pgf_pkg::in_req_t            hdr_q;
	logic [pgf_pkg::SEQ_W-1:0]   seq_q;
	logic [pgf_pkg::SEQ_W-1:0]   last_seq_q;
	logic [pgf_pkg::SEQ_W:0]     diff_q;
	logic [1:0]                  phase_q;

	logic       startup;
	logic [1:0] phase_dec;
	logic       ooo;
	logic       clip;

	assign in_ready  = (state_q == F_IDLE);
	assign startup   = (phase_q > 2'd1);
	assign phase_dec = (startup && hdr_q.spectral_quarter == '0) ? phase_q - 2'd1 : phase_q;
	assign ooo       = !startup && (diff_q[pgf_pkg::SEQ_W] || diff_q == '0);
	assign clip      = !startup && !ooo &&
		(diff_q > (pgf_pkg::SEQ_W + 1)'(pgf_pkg::MAX_FILL + 1));

	always_comb begin
		push_cmd.drop    = startup && (phase_dec > 2'd1);
		push_cmd.clip    = clip;
		push_cmd.ooo     = ooo;
		push_cmd.integ   = hdr_q.integration_count;
		push_cmd.quarter = hdr_q.spectral_quarter;
		push_cmd.beam    = hdr_q.beam_number;
		if (startup || ooo) begin
			push_cmd.fills = '0;
		end else if (clip) begin
			push_cmd.fills = pgf_pkg::FILL_W'(pgf_pkg::MAX_FILL);
		end else begin
			push_cmd.fills = diff_q[pgf_pkg::FILL_W-1:0] - 1'b1;
		end
	end

	assign push = (state_q == F_PUSH) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			hdr_q      <= '0;
			seq_q      <= '0;
			diff_q     <= '0;
			last_seq_q <= '0;
			phase_q    <= pgf_pkg::STARTUP_RESET;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						hdr_q   <= in_data;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					seq_q <= pgf_pkg::SEQ_W'(hdr_q.integration_count) * pgf_pkg::SEQ_W'(qps)
						+ pgf_pkg::SEQ_W'(hdr_q.spectral_quarter);
					state_q <= F_SUB;
				end
				F_SUB: begin
					diff_q  <= {1'b0, seq_q} - {1'b0, last_seq_q};
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						if (startup) begin
							phase_q <= (phase_dec > 2'd1) ? phase_dec : 2'd0;
						end
						if (!push_cmd.drop) begin
							last_seq_q <= seq_q;
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/pgf_queue.sv =====
module pgf_queue #(
	parameter int DEPTH = pgf_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pgf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output pgf_pkg::cmd_t head,
	output logic          empty
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	pgf_pkg::cmd_t    mem_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] wr_idx;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign head   = mem_q[0];
	assign wr_idx = pop ? count_q - 1'b1 : count_q;

	// Entries shift toward the head on a pop, so the oldest request always sits in entry 0.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (push && wr_idx == CNT_W'(i)) begin
				mem_q[i] <= push_cmd;
			end else if (pop && i < DEPTH - 1) begin
				mem_q[i] <= mem_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/pgf_back.sv =====
module pgf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pgf_pkg::QUARTER_W-1:0]  qps,
	input  logic [pgf_pkg::PPC_W-1:0]      ppc,
	input  logic                           empty,
	input  pgf_pkg::cmd_t                  head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pgf_pkg::out_req_t              out_data
);

	typedef enum logic [1:0] {B_IDLE, B_MOD, B_FILL, B_REAL} state_t;

	localparam int STEP_W = $clog2(pgf_pkg::QUARTER_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(pgf_pkg::QUARTER_W - 1);

	state_t                          state_q;
	pgf_pkg::cmd_t                   cmd_q;
	logic [pgf_pkg::FILL_W-1:0]      fill_cnt_q;
	logic [pgf_pkg::QUARTER_W-1:0]   lq_q;
	logic [pgf_pkg::INTEG_W-1:0]     li_q;
	logic [pgf_pkg::PPC_W-1:0]       pos_q;
	logic [pgf_pkg::QUARTER_W-1:0]   rem_q;
	logic [pgf_pkg::QUARTER_W-1:0]   dvd_q;
	logic [STEP_W-1:0]               step_q;
	logic                            out_valid_q;
	pgf_pkg::out_req_t               out_q;

	logic                            slot;
	logic                            emit;
	logic [pgf_pkg::QUARTER_W:0]     nq_inc;
	logic [pgf_pkg::QUARTER_W-1:0]   nq;
	logic [pgf_pkg::INTEG_W-1:0]     fi;
	logic [pgf_pkg::PPC_W-1:0]       limit;
	logic                            chunk_end;
	logic [pgf_pkg::PPC_W-1:0]       pos_next;
	logic [pgf_pkg::QUARTER_W:0]     trial;
	logic [pgf_pkg::QUARTER_W:0]     trial_sub;
	logic [pgf_pkg::QUARTER_W-1:0]   rem_next;

	assign slot      = !out_valid_q || out_ready;
	assign emit      = slot && (state_q == B_FILL || state_q == B_REAL);
	assign nq_inc    = {1'b0, lq_q} + 1'b1;
	assign nq        = (nq_inc == {1'b0, qps}) ? '0 : nq_inc[pgf_pkg::QUARTER_W-1:0];
	assign fi        = (nq == '0) ? li_q + 1'b1 : li_q;
	assign limit     = ppc - 1'b1;
	assign chunk_end = (pos_q >= limit);
	assign pos_next  = chunk_end ? '0 : pos_q + 1'b1;

	// One restoring-division step reduces a stored quarter that lies at or beyond the quarter register.
	assign trial     = {rem_q, dvd_q[pgf_pkg::QUARTER_W-1]};
	assign trial_sub = trial - {1'b0, qps};
	assign rem_next  = (trial >= {1'b0, qps}) ? trial_sub[pgf_pkg::QUARTER_W-1:0]
		: trial[pgf_pkg::QUARTER_W-1:0];

	assign pop       = (state_q == B_IDLE) && !empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cmd_q       <= '0;
			fill_cnt_q  <= '0;
			lq_q        <= '0;
			li_q        <= '0;
			pos_q       <= '0;
			rem_q       <= '0;
			dvd_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						if (head.drop) begin
							lq_q <= head.quarter;
							li_q <= head.integ;
						end else begin
							cmd_q      <= head;
							fill_cnt_q <= head.fills;
							if (head.fills == '0) begin
								state_q <= B_REAL;
							end else if (lq_q >= qps) begin
								rem_q   <= '0;
								dvd_q   <= lq_q;
								step_q  <= '0;
								state_q <= B_MOD;
							end else begin
								state_q <= B_FILL;
							end
						end
					end
				end
				B_MOD: begin
					rem_q  <= rem_next;
					dvd_q  <= dvd_q << 1;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						lq_q    <= rem_next;
						state_q <= B_FILL;
					end
				end
				B_FILL: begin
					if (slot) begin
						out_q.is_fill         <= 1'b1;
						out_q.out_integration <= fi;
						out_q.out_quarter     <= nq;
						out_q.out_beam        <= cmd_q.beam;
						out_q.gap_clipped     <= 1'b0;
						out_q.out_of_order    <= 1'b0;
						out_q.end_of_chunk    <= chunk_end;
						out_q.last_of_run     <= 1'b0;
						pos_q                 <= pos_next;
						lq_q                  <= nq;
						li_q                  <= fi;
						fill_cnt_q            <= fill_cnt_q - 1'b1;
						if (fill_cnt_q == pgf_pkg::FILL_W'(1)) begin
							state_q <= B_REAL;
						end
					end
				end
				B_REAL: begin
					if (slot) begin
						out_q.is_fill         <= 1'b0;
						out_q.out_integration <= cmd_q.integ;
						out_q.out_quarter     <= cmd_q.quarter;
						out_q.out_beam        <= cmd_q.beam;
						out_q.gap_clipped     <= cmd_q.clip;
						out_q.out_of_order    <= cmd_q.ooo;
						out_q.end_of_chunk    <= chunk_end;
						out_q.last_of_run     <= 1'b1;
						pos_q                 <= pos_next;
						lq_q                  <= cmd_q.quarter;
						li_q                  <= cmd_q.integ;
						state_q               <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/pgf_checker.sv =====
module pgf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input pgf_pkg::out_req_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result changed or vanished while the receiver stalled.");

	a_fill_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_fill |->
			!out_data.gap_clipped && !out_data.out_of_order && !out_data.last_of_run)
		else $error("Fill header carries a real-header flag.");

	a_real_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_fill |-> out_data.last_of_run)
		else $error("Real header does not close its run.");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.gap_clipped && out_data.out_of_order))
		else $error("Header is both clipped and out of order.");

endmodule

bind packet_gap_filler_top pgf_checker u_pgf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam logic [63:0] SEQ_MASK = 64'h00FF_FFFF_FFFF_FFFF;
	localparam logic [47:0] INTEG_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int LIMIT = 500000;
	localparam int SETTLE = 40;
	localparam int LONG_STALL = 400;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pgf_pkg::in_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pgf_pkg::out_req_t out_data;
	logic cfg_we = 1'b0;
	logic [pgf_pkg::CFG_IDX_W-1:0] cfg_index = pgf_pkg::CFG_QPS;
	logic [pgf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	packet_gap_filler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Register copies and sequence history used to predict the headers.
	logic [pgf_pkg::QUARTER_W-1:0] qps = pgf_pkg::QPS_RESET;
	logic [pgf_pkg::PPC_W-1:0] ppc = pgf_pkg::PPC_RESET;
	logic [1:0] startup_left = pgf_pkg::STARTUP_RESET;
	logic [pgf_pkg::INTEG_W-1:0] last_integ = '0;
	logic [pgf_pkg::QUARTER_W-1:0] last_q = '0;
	logic [pgf_pkg::SEQ_W-1:0] last_seq = '0;
	logic [pgf_pkg::PPC_W-1:0] chunk_pos = '0;

	pgf_pkg::in_req_t pending_headers[$];
	pgf_pkg::out_req_t expected_headers[$];
	logic [pgf_pkg::INTEG_W-1:0] gen_integ = '0;
	logic [pgf_pkg::QUARTER_W-1:0] gen_q = '0;

	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_sender = 1'b0;
	bit in_taken = 1'b0;
	bit stall_go = 1'b0;
	bit stall_seen = 1'b0;
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic predict_headers(input pgf_pkg::in_req_t req);
		logic [63:0] qeff;
		logic [63:0] seq;
		logic [63:0] gap;
		int fills;
		int k;
		logic clip;
		logic ooo;
		pgf_pkg::out_req_t hdr;
		qeff = (qps == 0) ? 64'd1 : 64'(qps);
		seq = (64'(req.integration_count) * qeff + 64'(req.spectral_quarter)) & SEQ_MASK;
		clip = 1'b0;
		ooo = 1'b0;
		fills = 0;
		if (startup_left > 1) begin
			if (req.spectral_quarter == 0)
				startup_left = startup_left - 2'd1;
			if (startup_left > 1) begin
				last_integ = req.integration_count;
				last_q = req.spectral_quarter;
				return;
			end
		end
		if (startup_left == 1) begin
			startup_left = 2'd0;
		end else if (seq <= 64'(last_seq)) begin
			ooo = 1'b1;
		end else begin
			gap = seq - 64'(last_seq) - 64'd1;
			if (gap > pgf_pkg::MAX_FILL) begin
				fills = pgf_pkg::MAX_FILL;
				clip = 1'b1;
			end else begin
				fills = int'(gap);
			end
		end
		// Fill headers come first; the last pass of the loop is the real request.
		for (k = 0; k <= fills; k++) begin
			hdr = '0;
			hdr.out_beam = req.beam_number;
			if (k < fills) begin
				hdr.is_fill = 1'b1;
				hdr.out_quarter = 8'((64'(last_q) + 64'd1) % qeff);
				hdr.out_integration = last_integ + 48'(hdr.out_quarter == 0);
			end else begin
				hdr.out_integration = req.integration_count;
				hdr.out_quarter = req.spectral_quarter;
				hdr.gap_clipped = clip;
				hdr.out_of_order = ooo;
				hdr.last_of_run = 1'b1;
			end
			last_integ = hdr.out_integration;
			last_q = hdr.out_quarter;
			if (chunk_pos >= ppc - 16'd1) begin
				hdr.end_of_chunk = 1'b1;
				chunk_pos = '0;
			end else begin
				chunk_pos = chunk_pos + 16'd1;
			end
			expected_headers.push_back(hdr);
		end
		last_seq = seq[pgf_pkg::SEQ_W-1:0];
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		pgf_pkg::out_req_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_headers.size() == 0) begin
					$display("%0t: unexpected header: expected none, got %h", $time, out_data);
					mismatches++;
				end else begin
					want = expected_headers.pop_front();
					check_field("is_fill", 64'(want.is_fill), 64'(out_data.is_fill));
					check_field("out_integration", 64'(want.out_integration),
						64'(out_data.out_integration));
					check_field("out_quarter", 64'(want.out_quarter),
						64'(out_data.out_quarter));
					check_field("out_beam", 64'(want.out_beam), 64'(out_data.out_beam));
					check_field("gap_clipped", 64'(want.gap_clipped),
						64'(out_data.gap_clipped));
					check_field("out_of_order", 64'(want.out_of_order),
						64'(out_data.out_of_order));
					check_field("end_of_chunk", 64'(want.end_of_chunk),
						64'(out_data.end_of_chunk));
					check_field("last_of_run", 64'(want.last_of_run),
						64'(out_data.last_of_run));
				end
			end
			if (in_valid && in_ready)
				predict_headers(in_data);
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_headers.size() != 0 && !hold_sender &&
					$urandom_range(99) >= send_idle_pct) begin
				in_data <= pending_headers.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_go != stall_seen) begin
			stall_seen <= stall_go;
			stall_left <= LONG_STALL;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_header(input logic [47:0] integ, input logic [7:0] q,
			input logic [7:0] beam);
		pgf_pkg::in_req_t req;
		req.integration_count = integ;
		req.spectral_quarter = q;
		req.beam_number = beam;
		pending_headers.push_back(req);
		gen_integ = integ;
		gen_q = q;
	endtask

	// Mostly well-formed streams with gaps of various sizes; some repeats and noise.
	task automatic push_random(input int count);
		logic [63:0] qeff;
		logic [63:0] seq;
		logic [47:0] integ;
		logic [7:0] q;
		int pick;
		qeff = (qps == 0) ? 64'd1 : 64'(qps);
		repeat (count) begin
			pick = $urandom_range(99);
			seq = 64'(gen_integ) * qeff + 64'(gen_q);
			integ = gen_integ;
			q = gen_q;
			if (pick < 75) begin
				if (pick < 55)
					seq = seq + 64'd1;
				else if (pick < 70)
					seq = seq + 64'($urandom_range(6, 2));
				else
					seq = seq + 64'($urandom_range(66, 63));
				integ = 48'(seq / qeff);
				q = 8'(seq % qeff);
			end else if (pick < 82) begin
				integ = gen_integ + 48'($urandom_range(1 << 20, 1));
			end else if (pick < 89) begin
				integ = gen_integ - 48'($urandom_range(3, 0));
				q = 8'($urandom_range(int'(qeff) - 1, 0));
			end else if (pick < 94) begin
				q = 8'($urandom_range(255, int'(qeff)));
			end else begin
				integ = 48'({$urandom, $urandom});
				q = 8'($urandom);
			end
			push_header(integ, q, 8'($urandom));
		end
	endtask

	task automatic write_reg(input logic [pgf_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == pgf_pkg::CFG_QPS)
			qps = value[7:0];
		else
			ppc = value;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pending_headers.size() != 0 || in_valid || expected_headers.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] quarters, input logic [15:0] per_chunk,
			input int send_pct, input int recv_pct);
		drain();
		write_reg(pgf_pkg::CFG_QPS, {8'($urandom), quarters});
		write_reg(pgf_pkg::CFG_PPC, per_chunk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	initial begin
		send_idle_pct = 25;
		recv_idle_pct = 54;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Start-up drops everything up to the second request with quarter zero.
		push_header(48'd5, 8'd2, 8'h00);
		push_header(48'd0, 8'd0, 8'hFF);
		push_header(INTEG_MAX, 8'd255, 8'h55);
		push_header(48'd10, 8'd0, 8'hAA);
		push_header(48'd10, 8'd1, 8'h00);
		push_header(48'd10, 8'd3, 8'hFF);
		push_header(48'd11, 8'd1, 8'h12);
		push_header(48'd11, 8'd1, 8'h34);
		push_header(48'd9, 8'd0, 8'h56);
		push_header(48'd30, 8'd0, 8'h78);
		push_header(48'd46, 8'd0, 8'h9A);
		push_header(48'd62, 8'd1, 8'hBC);
		push_header(48'd62, 8'd200, 8'hDE);
		push_header(48'd112, 8'd5, 8'hF0);
		push_header(48'd112, 8'd255, 8'h0F);
		push_header(INTEG_MAX, 8'd3, 8'hFF);
		push_header(INTEG_MAX, 8'd6, 8'h00);
		push_header(INTEG_MAX, 8'd6, 8'h81);
		push_header(48'd0, 8'd0, 8'h7E);
		push_random(40);
		while (pending_headers.size() >= 30)
			@(posedge clk);
		stall_go = ~stall_go;

		configure(8'd1, 16'd1, 25, 54);
		push_random(45);

		configure(8'd255, 16'd65535, 54, 25);
		push_random(45);
		while (pending_headers.size() >= 30)
			@(posedge clk);
		hold_sender = 1'b1;
		do
			@(posedge clk);
		while (in_valid || expected_headers.size() != 0);
		hold_sender = 1'b0;

		configure(8'd0, 16'd0, 54, 25);
		push_random(45);

		configure(8'd3, 16'd7, 0, 0);
		push_random(45);

		configure(8'd17, 16'd2, 0, 0);
		push_random(45);

		drain();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
